// ===== hw/rtl/smi_pkg.sv =====
// smi_pkg: shared types, constants and lookup tables for the stepper motor indexer.
// Used by every module under hw/rtl; depends on nothing.
package smi_pkg;

    localparam int MICROSTEPS_DEF = 8;
    localparam int FULL_TABLE     = 32;

    localparam logic [23:0] MIN_PERIOD = 24'd100;

    // configuration register indexes
    localparam logic [1:0] CFG_DRIVE_MODE  = 2'd0;
    localparam logic [1:0] CFG_INVERT_DIR  = 2'd1;
    localparam logic [1:0] CFG_DRIVE_LEVEL = 2'd2;

    // drive modes (any mode with bit 1 set is step/dir)
    localparam logic [1:0] MODE_HALF  = 2'd0;
    localparam logic [1:0] MODE_MICRO = 2'd1;

    // item kinds
    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // winding drive codes
    localparam logic [1:0] WIND_OFF = 2'd0;
    localparam logic [1:0] WIND_POS = 2'd1;
    localparam logic [1:0] WIND_NEG = 2'd2;

    typedef struct packed {
        logic [1:0] drive_mode;
        logic       invert_direction;
        logic [7:0] drive_level;
    } cfg_t;

    typedef struct packed {
        logic              timer_run;
        logic [23:0]       timer_period;
        logic              is_moving;
        logic signed [31:0] current_position;
        logic              step_direction;
        logic              step_pulse;
        logic [7:0]        pwm_b;
        logic [7:0]        pwm_a;
        logic [1:0]        winding_b;
        logic [1:0]        winding_a;
    } result_t;

    function automatic logic [1:0] half_a(input logic [2:0] h);
        logic [1:0] w;
        case (h)
            3'd0, 3'd1, 3'd2: w = WIND_POS;
            3'd4, 3'd5, 3'd6: w = WIND_NEG;
            default:          w = WIND_OFF;
        endcase
        return w;
    endfunction

    function automatic logic [1:0] half_b(input logic [2:0] h);
        logic [1:0] w;
        case (h)
            3'd0, 3'd6, 3'd7: w = WIND_NEG;
            3'd2, 3'd3, 3'd4: w = WIND_POS;
            default:          w = WIND_OFF;
        endcase
        return w;
    endfunction

    // quarter sine, 0..255 over 33 points
    function automatic logic [7:0] sine_q(input logic [5:0] idx);
        logic [7:0] v;
        case (idx)
            6'd0:  v = 8'd0;    6'd1:  v = 8'd12;   6'd2:  v = 8'd25;   6'd3:  v = 8'd37;
            6'd4:  v = 8'd50;   6'd5:  v = 8'd62;   6'd6:  v = 8'd74;   6'd7:  v = 8'd86;
            6'd8:  v = 8'd98;   6'd9:  v = 8'd109;  6'd10: v = 8'd121;  6'd11: v = 8'd131;
            6'd12: v = 8'd142;  6'd13: v = 8'd153;  6'd14: v = 8'd163;  6'd15: v = 8'd172;
            6'd16: v = 8'd181;  6'd17: v = 8'd190;  6'd18: v = 8'd198;  6'd19: v = 8'd206;
            6'd20: v = 8'd213;  6'd21: v = 8'd220;  6'd22: v = 8'd226;  6'd23: v = 8'd232;
            6'd24: v = 8'd237;  6'd25: v = 8'd241;  6'd26: v = 8'd245;  6'd27: v = 8'd249;
            6'd28: v = 8'd251;  6'd29: v = 8'd252;  6'd30: v = 8'd253;  6'd31: v = 8'd254;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/smi_cfg_regs.sv =====
// smi_cfg_regs: configuration register file (drive mode, invert, drive level).
// Depends on smi_pkg.
module smi_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output smi_pkg::cfg_t     cfg
);

    smi_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_mode       <= smi_pkg::MODE_HALF;
            cfg_reg.invert_direction <= 1'b0;
            cfg_reg.drive_level      <= 8'd255;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                smi_pkg::CFG_DRIVE_MODE:  cfg_reg.drive_mode       <= cfg_data[1:0];
                smi_pkg::CFG_INVERT_DIR:  cfg_reg.invert_direction <= cfg_data[0];
                smi_pkg::CFG_DRIVE_LEVEL: cfg_reg.drive_level      <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/smi_duty.sv =====
// smi_duty: one microstep duty value, sine table entry scaled by level/255.
// Depends on smi_pkg.
module smi_duty
#(
    parameter int MICROSTEPS = smi_pkg::MICROSTEPS_DEF
)
(
    input  logic [$clog2(MICROSTEPS+1)-1:0] n,
    input  logic [7:0]                      level,
    output logic [7:0]                      duty
);

    localparam int NW     = $clog2(MICROSTEPS + 1);
    localparam int STRIDE = smi_pkg::FULL_TABLE / MICROSTEPS;

    logic [NW+5:0] idx_full;
    logic [5:0]    idx;
    logic [15:0]   prod;
    logic [16:0]   scaled;

    assign idx_full = (NW + 6)'(n) * (NW + 6)'(STRIDE);
    assign idx      = (idx_full > (NW + 6)'(smi_pkg::FULL_TABLE)) ? 6'(smi_pkg::FULL_TABLE)
                                                                  : idx_full[5:0];
    assign prod     = 16'(smi_pkg::sine_q(idx)) * 16'(level);
    // exact floor(x/255) for x up to 255*255, the largest product
    assign scaled   = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    assign duty     = scaled[15:8];

endmodule

// ===== hw/rtl/smi_step_engine.sv =====
// smi_step_engine: motion state (position, goal, phases, drive, timer) and the
// per-transaction next-state logic. Depends on smi_pkg and smi_duty.
module smi_step_engine
#(
    parameter int MICROSTEPS = smi_pkg::MICROSTEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  smi_pkg::cfg_t      cfg,
    input  logic               kind,
    input  logic signed [31:0] target_position,
    input  logic [23:0]        step_period,
    output smi_pkg::result_t   result
);

    localparam int PW = $clog2(MICROSTEPS);
    localparam int NW = $clog2(MICROSTEPS + 1);
    localparam logic [PW-1:0] PMAX = PW'(MICROSTEPS - 1);

    logic signed [31:0] pos_reg, pos_next;
    logic signed [31:0] goal_reg, goal_next;
    logic               moving_reg, moving_next;
    logic               fwd_reg, fwd_next;
    logic [2:0]         hp_reg, hp_next;
    logic [1:0]         quad_reg, quad_next;
    logic [PW-1:0]      sub_reg, sub_next;
    logic [1:0]         wa_reg, wa_next, wb_reg, wb_next;
    logic [7:0]         da_reg, da_next, db_reg, db_next;
    logic [23:0]        per_reg, per_next;
    logic               run_reg, run_next;

    logic [2:0]    hp_adv, h_idx;
    logic [1:0]    quad_adv;
    logic [PW-1:0] sub_adv;
    logic [NW-1:0] n_p, n_j, n_a, n_b;
    logic [7:0]    duty_a, duty_b;
    logic          pulse;
    logic          stepdir;

    // phase advance for one step in the latched direction
    assign hp_adv   = fwd_reg ? hp_reg + 3'd1 : hp_reg - 3'd1;
    assign h_idx    = cfg.invert_direction ? 3'd7 - hp_adv : hp_adv;
    assign sub_adv  = fwd_reg ? ((sub_reg == PMAX) ? '0 : sub_reg + PW'(1))
                              : ((sub_reg == '0) ? PMAX : sub_reg - PW'(1));
    assign quad_adv = fwd_reg ? quad_reg + 2'((sub_reg == PMAX))
                              : quad_reg - 2'((sub_reg == '0));
    assign n_p      = NW'(sub_adv);
    assign n_j      = NW'(MICROSTEPS) - n_p;
    assign n_a      = quad_adv[0] ? n_p : n_j;
    assign n_b      = quad_adv[0] ? n_j : n_p;
    assign stepdir  = cfg.drive_mode[1];

    smi_duty #(.MICROSTEPS(MICROSTEPS)) u_duty_a
    (
        .n     (n_a),
        .level (cfg.drive_level),
        .duty  (duty_a)
    );

    smi_duty #(.MICROSTEPS(MICROSTEPS)) u_duty_b
    (
        .n     (n_b),
        .level (cfg.drive_level),
        .duty  (duty_b)
    );

    always_comb
    begin
        pos_next    = pos_reg;
        goal_next   = goal_reg;
        moving_next = moving_reg;
        fwd_next    = fwd_reg;
        hp_next     = hp_reg;
        quad_next   = quad_reg;
        sub_next    = sub_reg;
        wa_next     = wa_reg;
        wb_next     = wb_reg;
        da_next     = da_reg;
        db_next     = db_reg;
        per_next    = per_reg;
        run_next    = run_reg;
        pulse       = 1'b0;

        if (kind == smi_pkg::KIND_MOVE)
        begin
            goal_next = target_position;
            if (pos_reg == target_position)
            begin
                moving_next = 1'b0;
                fwd_next    = 1'b0;
                wa_next     = smi_pkg::WIND_OFF;
                wb_next     = smi_pkg::WIND_OFF;
            end
            else
            begin
                moving_next = 1'b1;
                fwd_next    = !(target_position < pos_reg);
                per_next    = (step_period < smi_pkg::MIN_PERIOD) ? smi_pkg::MIN_PERIOD
                                                                 : step_period;
                run_next    = 1'b1;
            end
        end
        else if (moving_reg && (pos_reg == goal_reg))
        begin
            moving_next = 1'b0;
            fwd_next    = 1'b0;
            wa_next     = smi_pkg::WIND_OFF;
            wb_next     = smi_pkg::WIND_OFF;
            run_next    = 1'b0;
        end
        else if (moving_reg)
        begin
            pos_next  = fwd_reg ? pos_reg + 32'sd1 : pos_reg - 32'sd1;
            hp_next   = hp_adv;
            quad_next = quad_adv;
            sub_next  = sub_adv;
            pulse     = stepdir;
            case (cfg.drive_mode)
                smi_pkg::MODE_HALF:
                begin
                    wa_next = smi_pkg::half_a(h_idx);
                    wb_next = smi_pkg::half_b(h_idx);
                end
                smi_pkg::MODE_MICRO:
                begin
                    da_next = duty_a;
                    db_next = duty_b;
                    if (quad_adv[0])
                    begin
                        wa_next = (quad_adv == 2'd1) ? smi_pkg::WIND_POS : smi_pkg::WIND_NEG;
                        wb_next = (quad_adv == 2'd1) ? smi_pkg::WIND_NEG : smi_pkg::WIND_POS;
                    end
                    else
                    begin
                        wa_next = (quad_adv == 2'd0) ? smi_pkg::WIND_POS : smi_pkg::WIND_NEG;
                        wb_next = (quad_adv == 2'd0) ? smi_pkg::WIND_POS : smi_pkg::WIND_NEG;
                    end
                end
                default: ;
            endcase
        end

        result.winding_a        = stepdir ? smi_pkg::WIND_OFF : wa_next;
        result.winding_b        = stepdir ? smi_pkg::WIND_OFF : wb_next;
        result.pwm_a            = (cfg.drive_mode == smi_pkg::MODE_MICRO) ? da_next : 8'd0;
        result.pwm_b            = (cfg.drive_mode == smi_pkg::MODE_MICRO) ? db_next : 8'd0;
        result.step_pulse       = pulse;
        result.step_direction   = fwd_next ^ cfg.invert_direction;
        result.current_position = pos_next;
        result.is_moving        = moving_next;
        result.timer_period     = per_next;
        result.timer_run        = run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            goal_reg   <= '0;
            moving_reg <= 1'b0;
            fwd_reg    <= 1'b0;
            hp_reg     <= '0;
            quad_reg   <= '0;
            sub_reg    <= '0;
            wa_reg     <= smi_pkg::WIND_OFF;
            wb_reg     <= smi_pkg::WIND_OFF;
            da_reg     <= '0;
            db_reg     <= '0;
            per_reg    <= '0;
            run_reg    <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg    <= pos_next;
            goal_reg   <= goal_next;
            moving_reg <= moving_next;
            fwd_reg    <= fwd_next;
            hp_reg     <= hp_next;
            quad_reg   <= quad_next;
            sub_reg    <= sub_next;
            wa_reg     <= wa_next;
            wb_reg     <= wb_next;
            da_reg     <= da_next;
            db_reg     <= db_next;
            per_reg    <= per_next;
            run_reg    <= run_next;
        end
    end

endmodule

// ===== hw/rtl/stepper_motor_indexer_core.sv =====
// stepper_motor_indexer_core: top level, input register, output register, handshakes.
// Depends on smi_pkg, smi_cfg_regs, smi_step_engine.
//
//  channel   | direction | transaction when         | payload
//  ----------+-----------+--------------------------+---------------------------------
//  s_*       | in        | s_tvalid && s_tready     | tuser: kind; tdata: target, period
//  m_*       | out       | m_tvalid && m_tready     | tdata: one result per item
//  cfg_*     | in        | cfg_valid && cfg_ready   | cfg_index, cfg_data
//
// One item per cycle sustained while m_tready is high; an item passes the input
// register, then the state update and result register in one pass, before m_tvalid rises.
// The position/phase state is updated in the same cycle the result register loads.
// Reset clears the motion state and all valid flags; no clearing pass.
// A stalled output holds its result; one further item waits in the input register.
module stepper_motor_indexer_core
#(
    parameter int MICROSTEPS = smi_pkg::MICROSTEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [31:0] target_position, [55:32] step_period
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [1:0] winding_a, [3:2] winding_b, [11:4] pwm_a,
                                   // [19:12] pwm_b, [20] step_pulse, [21] step_direction,
                                   // [53:22] current_position, [54] is_moving,
                                   // [78:55] timer_period, [79] timer_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    smi_pkg::cfg_t    cfg;
    smi_pkg::result_t result;

    logic               in_valid_reg;
    logic               in_kind_reg;
    logic signed [31:0] in_target_reg;
    logic [23:0]        in_period_reg;
    logic               out_valid_reg;
    smi_pkg::result_t   out_data_reg;
    logic               fire;

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    smi_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    smi_step_engine #(.MICROSTEPS(MICROSTEPS)) u_engine
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .cfg             (cfg),
        .kind            (in_kind_reg),
        .target_position (in_target_reg),
        .step_period     (in_period_reg),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg   <= s_tuser[0];
            in_target_reg <= $signed(s_tdata[31:0]);
            in_period_reg <= s_tdata[55:32];
        end
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    // a moving motor always has its tick timer running
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_data_reg.is_moving || out_data_reg.timer_run))
        else $error("moving with timer stopped");

    // a running timer was loaded with a clamped period
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.timer_run) |->
            (out_data_reg.timer_period >= smi_pkg::MIN_PERIOD))
        else $error("timer running below minimum period");

    // a step pulse only comes from a tick that leaves the motor moving
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.step_pulse) |-> out_data_reg.is_moving)
        else $error("step pulse while stopped");

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for stepper_motor_indexer_core, a motion tracker class
// predicts every result; tasks drive the item stream and the register channel, a receiver process drives m_tready.
// Depends on smi_pkg and the core RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smi_pkg::*;

    localparam int MSTEPS      = MICROSTEPS_DEF;
    localparam int IDLE_PCT    = 21;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    localparam logic [1:0] MODE_STEPDIR = 2'd2;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    // quarter sine, entry 0 in the lowest byte
    localparam logic [263:0] QSINE = {
        8'd255, 8'd254, 8'd253, 8'd252, 8'd251, 8'd249, 8'd245, 8'd241, 8'd237,
        8'd232, 8'd226, 8'd220, 8'd213, 8'd206, 8'd198, 8'd190, 8'd181, 8'd172,
        8'd163, 8'd153, 8'd142, 8'd131, 8'd121, 8'd109, 8'd98,  8'd86,  8'd74,
        8'd62,  8'd50,  8'd37,  8'd25,  8'd12,  8'd0};

    // half-step pattern, phase 0 in the lowest two bits
    localparam logic [15:0] HSTEP_A = {WIND_OFF, WIND_NEG, WIND_NEG, WIND_NEG,
                                       WIND_OFF, WIND_POS, WIND_POS, WIND_POS};
    localparam logic [15:0] HSTEP_B = {WIND_NEG, WIND_NEG, WIND_OFF, WIND_POS,
                                       WIND_POS, WIND_POS, WIND_OFF, WIND_NEG};

    typedef enum logic [1:0] {DIR_NONE = 2'd0, DIR_FWD = 2'd1, DIR_REV = 2'd3} dir_t;

    class motion_tracker;
        logic [1:0]  mode;
        logic        inv;
        logic [7:0]  level;
        logic [31:0] pos;
        logic [31:0] goal;
        logic        moving;
        dir_t        dir;
        logic [2:0]  half_ph;
        int          micro_ph;
        logic [1:0]  wa, wb;
        logic [7:0]  da, db;
        logic [23:0] tper;
        logic        trun;
        result_t     due_results[$];
        int          items_taken;
        int          results_seen;
        int          mismatches;

        function new();
            mode = MODE_HALF; inv = 1'b0; level = 8'd255;
            pos = '0; goal = '0; moving = 1'b0; dir = DIR_NONE;
            half_ph = '0; micro_ph = 0;
            wa = WIND_OFF; wb = WIND_OFF; da = '0; db = '0;
            tper = '0; trun = 1'b0;
            items_taken = 0; results_seen = 0; mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_DRIVE_MODE:  mode = val[1:0];
                CFG_INVERT_DIR:  inv = val[0];
                CFG_DRIVE_LEVEL: level = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] duty(int n);
            int idx;
            idx = n * (FULL_TABLE / MSTEPS);
            if (idx > FULL_TABLE)
                idx = FULL_TABLE;
            return 8'((int'(QSINE[idx*8 +: 8]) * int'(level)) / 255);
        endfunction

        function void step_phases(bit fwd);
            int span, s, p, j;
            logic [2:0] h;
            span = 4 * MSTEPS;
            half_ph = half_ph + (fwd ? 3'd1 : 3'd7);
            micro_ph = fwd ? (micro_ph + 1) % span : (micro_ph + span - 1) % span;
            if (mode == MODE_HALF)
            begin
                h = inv ? 3'd7 - half_ph : half_ph;
                wa = HSTEP_A[int'(h)*2 +: 2];
                wb = HSTEP_B[int'(h)*2 +: 2];
            end
            else if (mode == MODE_MICRO)
            begin
                s = micro_ph / MSTEPS;
                p = micro_ph % MSTEPS;
                j = MSTEPS - p;
                if (s % 2 == 1)
                begin
                    da = duty(p);
                    db = duty(j);
                    wa = (s == 1) ? WIND_POS : WIND_NEG;
                    wb = (s == 1) ? WIND_NEG : WIND_POS;
                end
                else
                begin
                    da = duty(j);
                    db = duty(p);
                    wa = (s == 0) ? WIND_POS : WIND_NEG;
                    wb = wa;
                end
            end
        endfunction

        function void take_item(logic kind, logic [31:0] tgt, logic [23:0] per);
            result_t r;
            logic    stepdir;
            logic    pulse;
            stepdir = mode[1];
            pulse = 1'b0;
            if (kind == KIND_MOVE)
            begin
                goal = tgt;
                if (pos == tgt)
                begin
                    moving = 1'b0; dir = DIR_NONE; wa = WIND_OFF; wb = WIND_OFF;
                end
                else
                begin
                    moving = 1'b1;
                    dir = ($signed(tgt) < $signed(pos)) ? DIR_REV : DIR_FWD;
                    tper = (per < MIN_PERIOD) ? MIN_PERIOD : per;
                    trun = 1'b1;
                end
            end
            else
            begin
                // arrival is noticed on the tick after the last step
                if (moving && pos == goal)
                begin
                    moving = 1'b0; dir = DIR_NONE; wa = WIND_OFF; wb = WIND_OFF;
                    trun = 1'b0;
                end
                if (moving && dir != DIR_NONE)
                begin
                    pos = (dir == DIR_FWD) ? pos + 32'd1 : pos - 32'd1;
                    step_phases(dir == DIR_FWD);
                    pulse = stepdir;
                end
            end
            r.winding_a        = stepdir ? WIND_OFF : wa;
            r.winding_b        = stepdir ? WIND_OFF : wb;
            r.pwm_a            = (mode == MODE_MICRO) ? da : 8'd0;
            r.pwm_b            = (mode == MODE_MICRO) ? db : 8'd0;
            r.step_pulse       = pulse;
            r.step_direction   = (dir == DIR_FWD) ^ inv;
            r.current_position = pos;
            r.is_moving        = moving;
            r.timer_period     = tper;
            r.timer_run        = trun;
            due_results.push_back(r);
            items_taken++;
        endfunction

        function void cmp(string field, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            cmp("winding_a",        want.winding_a,        got.winding_a);
            cmp("winding_b",        want.winding_b,        got.winding_b);
            cmp("pwm_a",            want.pwm_a,            got.pwm_a);
            cmp("pwm_b",            want.pwm_b,            got.pwm_b);
            cmp("step_pulse",       want.step_pulse,       got.step_pulse);
            cmp("step_direction",   want.step_direction,   got.step_direction);
            cmp("current_position", want.current_position, got.current_position);
            cmp("is_moving",        want.is_moving,        got.is_moving);
            cmp("timer_period",     want.timer_period,     got.timer_period);
            cmp("timer_run",        want.timer_run,        got.timer_run);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // [31:0] target_position, [55:32] step_period
    logic [0:0]  s_tuser;   // [0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // [1:0] winding_a, [3:2] winding_b, [11:4] pwm_a, [19:12] pwm_b,
                            // [20] step_pulse, [21] step_direction, [53:22] current_position,
                            // [54] is_moving, [78:55] timer_period, [79] timer_run
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    motion_tracker tracker;
    int  items_sent;
    int  cfg_writes;
    int  phases;
    bit  s_quiet;
    bit  m_quiet;
    int  hold_req;
    int  hold_seen;
    int  hold_left;
    int  stall_cycles;

    stepper_motor_indexer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, a quiet stretch, and one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= m_quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                tracker.write_reg(cfg_index, cfg_data);
                cfg_writes++;
            end
            if (s_tvalid && s_tready)
                tracker.take_item(s_tuser[0], s_tdata[31:0], s_tdata[55:32]);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("** stepper_motor_indexer_core: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic offer(logic kind, logic [31:0] tgt, logic [23:0] per);
        while (!s_quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {per, tgt};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic tick_n(int n);
        repeat (n)
            offer(KIND_TICK, $urandom, 24'($urandom_range(0, 24'hFFFFFF)));
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.items_taken != items_sent || tracker.due_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // mostly well-formed moves followed by enough ticks to arrive; the rest
    // are cut-short moves, lone ticks and moves to far targets
    task automatic run_random(int n);
        int          done;
        int          pick;
        int          offset;
        int          steps_away;
        int          nt;
        logic [23:0] per;
        done = 0;
        while (done < n)
        begin
            pick = $urandom_range(0, 99);
            per = $urandom_range(0, 1) ? 24'($urandom_range(0, 120))
                                       : 24'($urandom_range(0, 24'hFFFFFF));
            if (pick < 72)
            begin
                offset = $urandom_range(0, 40) - 20;
                steps_away = (offset < 0) ? -offset : offset;
                nt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, steps_away)
                                                 : steps_away + $urandom_range(0, 3);
                offer(KIND_MOVE, tracker.pos + offset, per);
                tick_n(nt);
                done += 1 + nt;
            end
            else if (pick < 86)
            begin
                tick_n(1);
                done++;
            end
            else
            begin
                nt = $urandom_range(0, 3);
                offer(KIND_MOVE, $urandom, per);
                tick_n(nt);
                done += 1 + nt;
            end
        end
    endtask

    task automatic run_phase(logic [1:0] mode, logic inv, logic [7:0] level, int n,
                             bit no_idle, bit hold_off);
        wait_idle();
        write_cfg(CFG_DRIVE_MODE, {6'd0, mode});
        write_cfg(CFG_INVERT_DIR, {7'd0, inv});
        write_cfg(CFG_DRIVE_LEVEL, level);
        cfg_valid <= 1'b0;
        phases++;
        if (hold_off)
        begin
            // sender keeps offering back to back while the receiver holds off
            s_quiet = 1'b1;
            hold_req <= hold_req + 1;
            run_random(40);
            s_quiet = 1'b0;
        end
        if (no_idle)
        begin
            s_quiet = 1'b1;
            m_quiet <= 1'b1;
        end
        run_random(n);
        if (no_idle)
        begin
            s_quiet = 1'b0;
            m_quiet <= 1'b0;
        end
    endtask

    initial
    begin
        tracker = new();
        items_sent = 0; cfg_writes = 0; phases = 1;
        s_quiet = 1'b0;
        hold_req = 0; hold_seen = 0; hold_left = 0; stall_cycles = 0;
        m_quiet <= 1'b0;
        m_tready <= 1'b0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= KIND_MOVE;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_DRIVE_MODE;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        tick_n(1);                          // tick with the timer stopped
        offer(KIND_MOVE, 32'd0, 24'd50);    // move to where it already is
        offer(KIND_MOVE, 32'd3, 24'd0);     // period clamps to the minimum
        tick_n(5);                          // three steps, arrival, stopped tick
        offer(KIND_MOVE, 32'hFFFF_FFFE, 24'hFF_FFFF);
        tick_n(2);
        offer(KIND_MOVE, 32'h7FFF_FFFF, 24'd99);
        tick_n(2);
        offer(KIND_MOVE, 32'h8000_0000, 24'd100);
        tick_n(3);
        offer(KIND_MOVE, 32'd1, 24'd101);
        tick_n(6);
        run_random(100);

        run_phase(MODE_MICRO,   1'b0, 8'd255, 150, 1'b0, 1'b0);
        run_phase(MODE_MICRO,   1'b1, 8'd0,   120, 1'b0, 1'b0);
        run_phase(MODE_STEPDIR, 1'b0, 8'd128, 150, 1'b1, 1'b0);
        run_phase(MODE_STEPDIR, 1'b1, 8'd77,  150, 1'b0, 1'b1);
        run_phase(MODE_SPARE,   1'b0, 8'd255, 100, 1'b0, 1'b0);
        run_phase(MODE_HALF,    1'b1, 8'd255, 150, 1'b0, 1'b0);
        run_phase(MODE_MICRO,   1'b0, 8'd1,   150, 1'b0, 1'b0);
        run_phase(MODE_HALF,    1'b0, 8'd0,   100, 1'b0, 1'b0);
        repeat (5)
            run_phase(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 130, 1'b0, 1'b0);

        wait_idle();
        repeat (4) @(posedge clk);
        tracker.mismatches += tracker.due_results.size();

        $display("Ran %0d items under %0d register settings (%0d register writes),",
                 items_sent, phases, cfg_writes);
        $display("checked %0d results across all drive modes, with one long output hold-off.",
                 tracker.results_seen);
        if (tracker.mismatches == 0)
            $display("** stepper_motor_indexer_core: PASSED **");
        else
            $display("** stepper_motor_indexer_core: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/smi_pkg.sv
hw/rtl/smi_cfg_regs.sv
hw/rtl/smi_duty.sv
hw/rtl/smi_step_engine.sv
hw/rtl/stepper_motor_indexer_core.sv
bench/tb_top.sv
